// ===== rtl/core/pip_pkg.sv =====
// Shared widths, codes and state types for the point-in-polygon block.
`timescale 1ns / 1ps
package pip_pkg;

	localparam int CoordW = 32;   // vertex and point coordinate width
	localparam int DiffW  = 33;   // coordinate difference width
	localparam int ProdW  = 66;   // product of two differences
	localparam int AccW   = 68;   // sum of two products, with headroom
	localparam int SqW    = 66;   // floored squared distance
	localparam int RootW  = 33;   // distance width
	localparam int VertW  = 2 * CoordW;

	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	typedef struct packed {
		logic [SqW-1:0] dist2;
		logic           crossing;
	} edge_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD0,
		ST_ISSUE,
		ST_RDB,
		ST_ESTART,
		ST_EWAIT,
		ST_RSTART,
		ST_RWAIT,
		ST_DONE
	} top_state_t;

	typedef enum logic [2:0] {
		E_IDLE,
		E_MUL,
		E_PICK,
		E_DIV,
		E_DONE
	} edge_state_t;

endpackage

// ===== rtl/core/point_in_polygon_edge_distance.sv =====
// Top level: polygon vertex store, edge sequencer and distance root.
//
//  channel  | handshake       | payload
//  ---------+-----------------+-------------------------------------------
//  command  | start / busy    | kind, coord_x, coord_y
//  result   | strobe (1 cyc)  | inside_res, edge_distance, vertex_overflow
//
// A word is taken on a rising edge with start high and busy low.
// Clear and append never raise busy; kind 3 is taken and does nothing.
// A query walks the edges one at a time through a single RAM read port;
// an edge whose projection falls inside the segment also runs a 66-step
// quotient, and the square root follows the last edge; an empty polygon
// skips both and goes straight to the done state.
// Reset empties the polygon and clears the overflow flag at once; the
// vertex RAM itself is not cleared. The result strobe cannot be stalled.
`timescale 1ns / 1ps
module point_in_polygon_edge_distance #(
	parameter int MAX_VERTICES = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  kind,
	input  logic signed [31:0]          coord_x,
	input  logic signed [31:0]          coord_y,
	output logic                        strobe,
	output logic                        inside_res,
	output logic [32:0]                 edge_distance,
	output logic                        vertex_overflow
);

	localparam int AddrW = $clog2(MAX_VERTICES > 1 ? MAX_VERTICES : 2);
	localparam int CntW  = $clog2(MAX_VERTICES + 1);

	pip_pkg::top_state_t state_q, state_d;

	logic                          accept;
	logic [CntW-1:0]               count_q, idx_q, idx_next;
	logic                          ovf_q, inside_q;
	logic signed [31:0]            px_q, py_q;
	logic [pip_pkg::VertW-1:0]     first_q, a_q, b_q, rdata;
	logic [pip_pkg::SqW-1:0]       best_q;
	logic [pip_pkg::RootW-1:0]     dist_q, root;
	logic                          we;
	logic [AddrW-1:0]              raddr;
	logic                          edge_start, edge_done, root_start, root_done;
	pip_pkg::edge_res_t            edge_res;
	logic                          last_edge;

	assign accept    = start && !busy;
	assign idx_next  = idx_q + 1'b1;
	assign last_edge = (idx_next == count_q);

	// append goes to the next free entry unless the store is full
	assign we    = accept && kind == pip_pkg::KIND_APPEND &&
		count_q != CntW'(MAX_VERTICES);
	assign raddr = (state_q == pip_pkg::ST_IDLE) ? '0 : idx_next[AddrW-1:0];

	pip_ram #(
		.WIDTH(pip_pkg::VertW),
		.DEPTH(MAX_VERTICES)
	) u_vram (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[AddrW-1:0]),
		.wdata ({coord_y, coord_x}),
		.raddr (raddr),
		.rdata (rdata)
	);

	pip_edge u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (edge_start),
		.px     (px_q),
		.py     (py_q),
		.ax     ($signed(a_q[31:0])),
		.ay     ($signed(a_q[63:32])),
		.bx     ($signed(b_q[31:0])),
		.by     ($signed(b_q[63:32])),
		.done   (edge_done),
		.res    (edge_res)
	);

	pip_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (best_q),
		.done     (root_done),
		.root     (root)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pip_pkg::ST_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && kind == pip_pkg::KIND_CLEAR) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (accept && kind == pip_pkg::KIND_APPEND) begin
				if (we) count_q <= count_q + 1'b1;
				else    ovf_q   <= 1'b1;
			end
		end
	end

	// next state and strobes
	always_comb begin
		state_d    = state_q;
		edge_start = 1'b0;
		root_start = 1'b0;
		case (state_q)
			pip_pkg::ST_IDLE: begin
				if (accept && kind == pip_pkg::KIND_QUERY) begin
					state_d = (count_q == '0) ? pip_pkg::ST_DONE : pip_pkg::ST_RD0;
				end
			end
			pip_pkg::ST_RD0:   state_d = pip_pkg::ST_RDB;
			pip_pkg::ST_ISSUE: state_d = pip_pkg::ST_RDB;
			pip_pkg::ST_RDB:   state_d = pip_pkg::ST_ESTART;
			pip_pkg::ST_ESTART: begin
				edge_start = 1'b1;
				state_d    = pip_pkg::ST_EWAIT;
			end
			pip_pkg::ST_EWAIT: begin
				if (edge_done) begin
					state_d = last_edge ? pip_pkg::ST_RSTART : pip_pkg::ST_ISSUE;
				end
			end
			pip_pkg::ST_RSTART: begin
				root_start = 1'b1;
				state_d    = pip_pkg::ST_RWAIT;
			end
			pip_pkg::ST_RWAIT: begin
				if (root_done) state_d = pip_pkg::ST_DONE;
			end
			pip_pkg::ST_DONE: state_d = pip_pkg::ST_IDLE;
			default:          state_d = pip_pkg::ST_IDLE;
		endcase
	end

	// query datapath
	always_ff @(posedge clk) begin
		case (state_q)
			pip_pkg::ST_IDLE: begin
				if (accept && kind == pip_pkg::KIND_QUERY) begin
					px_q     <= coord_x;
					py_q     <= coord_y;
					idx_q    <= '0;
					inside_q <= 1'b0;
					dist_q   <= '1;   // empty polygon saturates
				end
			end
			pip_pkg::ST_RD0: begin
				// hold vertex 0 for the closing edge
				first_q <= rdata;
				a_q     <= rdata;
			end
			pip_pkg::ST_RDB: begin
				b_q <= last_edge ? first_q : rdata;
			end
			pip_pkg::ST_EWAIT: begin
				if (edge_done) begin
					if (idx_q == '0 || edge_res.dist2 < best_q) best_q <= edge_res.dist2;
					inside_q <= inside_q ^ edge_res.crossing;
					a_q      <= b_q;
					idx_q    <= idx_next;
				end
			end
			pip_pkg::ST_RWAIT: begin
				if (root_done) dist_q <= root;
			end
			default: ;
		endcase
	end

	assign busy            = (state_q != pip_pkg::ST_IDLE);
	assign strobe          = (state_q == pip_pkg::ST_DONE);
	assign inside_res      = inside_q;
	assign edge_distance   = dist_q;
	assign vertex_overflow = ovf_q;

endmodule

// ===== rtl/core/pip_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pip_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]               wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]               rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/pip_edge.sv =====
// One polygon edge: squared distance to the segment and ray crossing.
`timescale 1ns / 1ps
module pip_edge (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [31:0]        px,
	input  logic signed [31:0]        py,
	input  logic signed [31:0]        ax,
	input  logic signed [31:0]        ay,
	input  logic signed [31:0]        bx,
	input  logic signed [31:0]        by,
	output logic                      done,
	output pip_pkg::edge_res_t        res
);

	pip_pkg::edge_state_t state_q, state_d;

	logic signed [pip_pkg::DiffW-1:0] dx, dy, sx, sy, ex, fy;
	logic signed [pip_pkg::DiffW-1:0] op_a, op_b;
	logic signed [pip_pkg::ProdW-1:0] prod_c, prod_q;
	logic signed [pip_pkg::AccW-1:0]  acc_q [6];
	logic [3:0]                        cnt_q, cnt_m1;
	logic [2:0]                        acc_idx;
	logic [pip_pkg::SqW-1:0]           q_q, q_n;
	logic [pip_pkg::SqW:0]             r_q, r_n, len_u, t_u;
	logic [6:0]                        bit_q;
	logic [pip_pkg::SqW-1:0]           dist_c;
	logic                              interior, cross_c;
	pip_pkg::edge_res_t                res_q;

	assign dx = pip_pkg::DiffW'(px) - pip_pkg::DiffW'(ax);
	assign dy = pip_pkg::DiffW'(py) - pip_pkg::DiffW'(ay);
	assign sx = pip_pkg::DiffW'(bx) - pip_pkg::DiffW'(ax);
	assign sy = pip_pkg::DiffW'(by) - pip_pkg::DiffW'(ay);
	assign ex = pip_pkg::DiffW'(px) - pip_pkg::DiffW'(bx);
	assign fy = pip_pkg::DiffW'(py) - pip_pkg::DiffW'(by);

	// products: t, t, |s|^2, |s|^2, |d|^2, |d|^2, |e|^2, |e|^2, lhs, rhs
	always_comb begin
		case (cnt_q)
			4'd0: begin op_a = dx; op_b = sx; end
			4'd1: begin op_a = dy; op_b = sy; end
			4'd2: begin op_a = sx; op_b = sx; end
			4'd3: begin op_a = sy; op_b = sy; end
			4'd4: begin op_a = dx; op_b = dx; end
			4'd5: begin op_a = dy; op_b = dy; end
			4'd6: begin op_a = ex; op_b = ex; end
			4'd7: begin op_a = fy; op_b = fy; end
			4'd8: begin op_a = dx; op_b = sy; end
			default: begin op_a = dy; op_b = sx; end
		endcase
	end

	assign prod_c = op_a * op_b;
	assign cnt_m1 = cnt_q - 4'd1;

	always_comb begin
		case (cnt_m1)
			4'd0, 4'd1: acc_idx = 3'd0;
			4'd2, 4'd3: acc_idx = 3'd1;
			4'd4, 4'd5: acc_idx = 3'd2;
			4'd6, 4'd7: acc_idx = 3'd3;
			4'd8:       acc_idx = 3'd4;
			default:    acc_idx = 3'd5;
		endcase
	end

	assign interior = (acc_q[0] > 0) && (acc_q[0] < acc_q[1]);
	assign cross_c  = ((dy < 0) != (fy < 0)) &&
		((sy > 0 && acc_q[4] < acc_q[5]) || (sy < 0 && acc_q[4] > acc_q[5]));

	assign len_u = acc_q[1][pip_pkg::SqW:0];
	assign t_u   = acc_q[0][pip_pkg::SqW:0];

	// one quotient step of floor(t*t / len), feeding one bit of t
	always_comb begin
		r_n = {r_q[pip_pkg::SqW-1:0], 1'b0};
		q_n = {q_q[pip_pkg::SqW-2:0], 1'b0};
		if (r_n >= len_u) begin
			r_n = r_n - len_u;
			q_n = q_n + 1'b1;
		end
		if (t_u[bit_q]) begin
			r_n = r_n + t_u;
			if (r_n >= len_u) begin
				r_n = r_n - len_u;
				q_n = q_n + 1'b1;
			end
		end
		dist_c = acc_q[2][pip_pkg::SqW-1:0] - q_n - pip_pkg::SqW'(r_n != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pip_pkg::E_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		case (state_q)
			pip_pkg::E_IDLE: begin
				if (start) state_d = pip_pkg::E_MUL;
			end
			pip_pkg::E_MUL: begin
				if (cnt_q == 4'd10) state_d = pip_pkg::E_PICK;
			end
			pip_pkg::E_PICK: begin
				state_d = interior ? pip_pkg::E_DIV : pip_pkg::E_DONE;
			end
			pip_pkg::E_DIV: begin
				if (bit_q == '0) state_d = pip_pkg::E_DONE;
			end
			pip_pkg::E_DONE: begin
				done    = 1'b1;
				state_d = pip_pkg::E_IDLE;
			end
			default: state_d = pip_pkg::E_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pip_pkg::E_IDLE: begin
				cnt_q <= '0;
				for (int i = 0; i < 6; i++) acc_q[i] <= '0;
			end
			pip_pkg::E_MUL: begin
				prod_q <= prod_c;
				if (cnt_q != 4'd0) begin
					acc_q[acc_idx] <= acc_q[acc_idx] + pip_pkg::AccW'(prod_q);
				end
				cnt_q <= cnt_q + 4'd1;
			end
			pip_pkg::E_PICK: begin
				res_q.crossing <= cross_c;
				if (acc_q[0] <= 0) begin
					res_q.dist2 <= acc_q[2][pip_pkg::SqW-1:0];
				end else begin
					res_q.dist2 <= acc_q[3][pip_pkg::SqW-1:0];
				end
				q_q   <= '0;
				r_q   <= '0;
				bit_q <= 7'(pip_pkg::SqW - 1);
			end
			pip_pkg::E_DIV: begin
				q_q   <= q_n;
				r_q   <= r_n;
				bit_q <= bit_q - 7'd1;
				if (bit_q == '0) res_q.dist2 <= dist_c;
			end
			default: ;
		endcase
	end

	assign res = res_q;

endmodule

// ===== rtl/core/pip_isqrt.sv =====
// Bit-serial integer square root, rounded down, two radicand bits a cycle.
`timescale 1ns / 1ps
module pip_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pip_pkg::SqW-1:0]    radicand,
	output logic                       done,
	output logic [pip_pkg::RootW-1:0]  root
);

	logic                        busy_q, done_q;
	logic [5:0]                  cnt_q;
	logic [pip_pkg::SqW-1:0]     rad_q;
	logic [pip_pkg::RootW+2:0]   rem_q, shifted, trial;
	logic [pip_pkg::RootW-1:0]   root_q;

	assign shifted = {rem_q[pip_pkg::RootW:0], rad_q[pip_pkg::SqW-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= 6'(pip_pkg::RootW - 1);
		end else if (busy_q) begin
			rad_q <= {rad_q[pip_pkg::SqW-3:0], 2'b00};
			cnt_q <= cnt_q - 6'd1;
			if (shifted >= trial) begin
				rem_q  <= shifted - trial;
				root_q <= {root_q[pip_pkg::RootW-2:0], 1'b1};
			end else begin
				rem_q  <= shifted;
				root_q <= {root_q[pip_pkg::RootW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
